// File: src/sawc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawc_pkg
// Shared types and constants for the set-associative write-back cache tags.
// ----------------------------------------------------------------------------
package sawc_pkg;

  localparam int unsigned DEF_MAX_SETS  = 256;
  localparam int unsigned DEF_MAX_WAYS  = 8;
  localparam int unsigned DEF_ADDR_BITS = 32;

  localparam int unsigned CFG_W      = 4;
  localparam int unsigned RANK_W     = 3;
  localparam logic [2:0]  RANK_MAX   = 3'd7;
  localparam int unsigned OFF_MAX    = 12;
  localparam int unsigned IDX_MAX    = 8;
  localparam int unsigned WAY_OUT_W  = 3;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_INDEX  = 2'd2;
  localparam logic [1:0] REG_WAYS   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_LOOKUP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch the access and issue the set read
    logic clr;       // clear the swept set
    logic update;    // decide, write back set state, emit result
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
  } ctrl_sts_t;

endpackage

// File: src/set_assoc_writeback_cache_tags.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache_tags
// Tag, dirty and replacement controller of a set-associative write-back cache.
// ----------------------------------------------------------------------------
// Pulse start with command/address while busy is low; the beat is taken then.
// The set row is read at that edge and written back with the updated tags,
// dirty bits, LRU ranks and FIFO pointer at the next edge. The result appears
// on the result ports for one cycle with done high, in the same cycle in which
// busy falls again, and cannot be held off. After reset a clearing sweep runs
// over all MAX_SETS rows with busy high; configuration writes are taken at any
// time but should only be made while idle.
module set_assoc_writeback_cache_tags #(
  parameter int unsigned MAX_SETS  = sawc_pkg::DEF_MAX_SETS,
  parameter int unsigned MAX_WAYS  = sawc_pkg::DEF_MAX_WAYS,
  parameter int unsigned ADDR_BITS = sawc_pkg::DEF_ADDR_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           command,
  input  logic [31:0]                    address,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [sawc_pkg::CFG_W-1:0]     cfg_data,
  output logic                           done,
  output logic                           hit,
  output logic [sawc_pkg::WAY_OUT_W-1:0] way,
  output logic                           fetch_request,
  output logic                           writeback_valid,
  output logic [31:0]                    writeback_address
);
  import sawc_pkg::*;

  logic             replacement_mode;
  logic [CFG_W-1:0] offset_bits, index_bits, ways_in_use;
  ctrl_cmd_t        cmd;
  ctrl_sts_t        sts;

  // configuration registers: hold until written
  always_ff @(posedge clk) begin
    if (rst) begin
      replacement_mode <= 1'b0;
      offset_bits      <= 4'd5;
      index_bits       <= 4'd5;
      ways_in_use      <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   replacement_mode <= cfg_data[0];
        REG_OFFSET: offset_bits      <= cfg_data;
        REG_INDEX:  index_bits       <= cfg_data;
        REG_WAYS:   ways_in_use      <= cfg_data;
        default:    replacement_mode <= replacement_mode;
      endcase
    end
  end

  sawc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  sawc_dp #(
    .MAX_SETS  (MAX_SETS),
    .MAX_WAYS  (MAX_WAYS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_mode          (replacement_mode),
    .cfg_off           (offset_bits),
    .cfg_idx           (index_bits),
    .cfg_ways          (ways_in_use),
    .command           (command),
    .address           (address),
    .done              (done),
    .hit               (hit),
    .way               (way),
    .fetch_request     (fetch_request),
    .writeback_valid   (writeback_valid),
    .writeback_address (writeback_address)
  );

`ifndef SYNTHESIS
  // every accepted beat yields a result with done once its update is registered
  a_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done) else $error("result missing");
  // hit and fetch are exclusive
  a_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> (hit != fetch_request)) else $error("hit/fetch clash");
  // writeback only on a miss
  a_wb: assert property (@(posedge clk) disable iff (rst)
    (done && writeback_valid) |-> fetch_request) else $error("writeback on hit");
`endif

endmodule

// File: src/sawc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawc_ctrl
// Sequencer: clearing sweep after reset, then read set / update set per beat.
// ----------------------------------------------------------------------------
module sawc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  sawc_pkg::ctrl_sts_t sts,
  output sawc_pkg::ctrl_cmd_t cmd,
  output logic                busy
);
  import sawc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (sts.clear_done) state_next = ST_IDLE;
      ST_IDLE:   if (start) state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_CLEAR:  cmd.clr = 1'b1;
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      ST_LOOKUP: cmd.update = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

endmodule

// File: src/sawc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawc_dp
// Set memory, tag compare, victim choice, recency update and result register.
// ----------------------------------------------------------------------------
module sawc_dp #(
  parameter int unsigned MAX_SETS  = sawc_pkg::DEF_MAX_SETS,
  parameter int unsigned MAX_WAYS  = sawc_pkg::DEF_MAX_WAYS,
  parameter int unsigned ADDR_BITS = sawc_pkg::DEF_ADDR_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sawc_pkg::ctrl_cmd_t                 cmd,
  output sawc_pkg::ctrl_sts_t                 sts,
  input  logic                                cfg_mode,
  input  logic [sawc_pkg::CFG_W-1:0]          cfg_off,
  input  logic [sawc_pkg::CFG_W-1:0]          cfg_idx,
  input  logic [sawc_pkg::CFG_W-1:0]          cfg_ways,
  input  logic                                command,
  input  logic [31:0]                         address,
  output logic                                done,
  output logic                                hit,
  output logic [sawc_pkg::WAY_OUT_W-1:0]      way,
  output logic                                fetch_request,
  output logic                                writeback_valid,
  output logic [31:0]                         writeback_address
);
  import sawc_pkg::*;

  localparam int unsigned SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned WCNT_W = $clog2(MAX_WAYS + 1);
  localparam int unsigned AW = ADDR_BITS;

  // One memory row per set: every way's fields side by side.
  typedef struct packed {
    logic              valid;
    logic              dirty;
    logic [RANK_W-1:0] rank;
    logic [AW-1:0]     tag;
  } line_t;

  typedef struct packed {
    line_t [MAX_WAYS-1:0] lines;
    logic  [WAY_W-1:0]    ptr;
  } row_t;

  row_t mem [MAX_SETS];
  row_t rd_row;

  logic [AW-1:0]     a_tag;
  logic [SET_W-1:0]  a_set;
  logic              a_wr;
  logic [3:0]        a_off;
  logic [4:0]        a_sh;
  logic [SET_W-1:0]  clr_set;

  // effective config
  logic [3:0]        off_e, ib_e;
  logic [4:0]        sh_e;
  logic [WCNT_W-1:0] ways_e;
  logic [AW-1:0]     addr_t;
  logic [AW-1:0]     set_full;

  always_comb begin
    off_e  = (cfg_off > 4'(OFF_MAX)) ? 4'(OFF_MAX) : cfg_off;
    ib_e   = (cfg_idx > 4'(IDX_MAX)) ? 4'(IDX_MAX) : cfg_idx;
    // tag shift reaches 20, so the sum needs five bits
    sh_e   = 5'(off_e) + 5'(ib_e);
    if (cfg_ways == 4'd0)                 ways_e = WCNT_W'(1);
    else if (32'(cfg_ways) > MAX_WAYS)    ways_e = WCNT_W'(MAX_WAYS);
    else                                  ways_e = WCNT_W'(cfg_ways);
    addr_t   = AW'({32'd0, address});
    set_full = (addr_t >> off_e) & ((AW'(1) << ib_e) - AW'(1));
  end

  // capture stage: latch access, read the set row
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      a_wr  <= command;
      a_off <= off_e;
      a_sh  <= sh_e;
      a_set <= SET_W'(set_full);
      a_tag <= addr_t >> sh_e;
      rd_row <= mem[SET_W'(set_full)];
    end
  end

  // clearing sweep
  always_ff @(posedge clk) begin
    if (rst) clr_set <= '0;
    else if (cmd.clr) clr_set <= clr_set + SET_W'(1);
  end
  assign sts.clear_done = cmd.clr && (32'(clr_set) == MAX_SETS - 1);

  // decision
  logic [MAX_WAYS-1:0] in_use, hit_vec, inv_vec;
  logic                f_hit, f_inv;
  logic [WAY_W-1:0]    hit_w, inv_w, lru_w, fifo_w, vic_w, sel_w;
  logic [RANK_W-1:0]   best_r, old_r;
  row_t                new_row;
  logic                vic_dirty;
  logic [AW-1:0]       wb_a;

  always_comb begin
    f_hit = 1'b0; f_inv = 1'b0;
    hit_w = '0; inv_w = '0; lru_w = '0; best_r = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use[i]  = (i < 32'(ways_e));
      hit_vec[i] = in_use[i] && rd_row.lines[i].valid && (rd_row.lines[i].tag == a_tag);
      inv_vec[i] = in_use[i] && !rd_row.lines[i].valid;
    end
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin f_hit = 1'b1; hit_w = WAY_W'(i); end
      if (inv_vec[i]) begin f_inv = 1'b1; inv_w = WAY_W'(i); end
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (in_use[i] && (i == 0 || rd_row.lines[i].rank > best_r)) begin
        best_r = rd_row.lines[i].rank;
        lru_w  = WAY_W'(i);
      end
    end
    fifo_w = (32'(rd_row.ptr) >= 32'(ways_e)) ? '0 : rd_row.ptr;
    vic_w  = cfg_mode ? fifo_w : lru_w;
    sel_w  = f_hit ? hit_w : (f_inv ? inv_w : vic_w);
    vic_dirty = !f_hit && !f_inv && rd_row.lines[vic_w].dirty;
    wb_a = (rd_row.lines[vic_w].tag << a_sh) | (AW'(a_set) << a_off);

    old_r = rd_row.lines[sel_w].valid ? rd_row.lines[sel_w].rank : RANK_MAX;
    new_row = rd_row;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (in_use[i] && WAY_W'(i) != sel_w && rd_row.lines[i].valid &&
          rd_row.lines[i].rank < old_r && rd_row.lines[i].rank != RANK_MAX)
        new_row.lines[i].rank = rd_row.lines[i].rank + RANK_W'(1);
    end
    new_row.lines[sel_w].rank = '0;
    if (f_hit) begin
      if (a_wr) new_row.lines[sel_w].dirty = 1'b1;
    end else begin
      new_row.lines[sel_w].valid = 1'b1;
      new_row.lines[sel_w].dirty = a_wr;
      new_row.lines[sel_w].tag   = a_tag;
      if (!f_inv && cfg_mode)
        new_row.ptr = (32'(fifo_w) + 1 >= 32'(ways_e)) ? '0 : fifo_w + WAY_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr)         mem[clr_set] <= '0;
    else if (cmd.update) mem[a_set]   <= new_row;
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= cmd.update;
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      hit               <= f_hit;
      way               <= WAY_OUT_W'(sel_w);
      fetch_request     <= !f_hit;
      writeback_valid   <= vic_dirty;
      writeback_address <= vic_dirty ? 32'(wb_a) : 32'd0;
    end
  end

endmodule
